/* sv/kct_pkg.sv */
// package for the keypad countdown timer
// holds the mode encoding, key codes and digit limits; no dependencies
package kct_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ENTER = 3'd1,
    MODE_ARMED = 3'd2,
    MODE_COUNT = 3'd3,
    MODE_DONE  = 3'd4
  } mode_t;

  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;

  localparam logic [3:0] TENS_LIMIT = 4'd5;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned IDX_W      = 3;

  localparam logic       KIND_KEY  = 1'b0;
  localparam logic       KIND_TICK = 1'b1;

endpackage

/* sv/kct_if.sv */
// valid/ready channels of the keypad countdown timer
// input items carry keypad samples or ticks, output items carry the display state
interface kct_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] key_code;

  modport source (output valid, kind, key_code, input ready);
  modport sink   (input valid, kind, key_code, output ready);
endinterface

interface kct_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] min_tens;
  logic [3:0] min_ones;
  logic [3:0] sec_tens;
  logic [3:0] sec_ones;
  logic [2:0] digits_entered;
  logic       finished;

  modport source (output valid, mode, min_tens, min_ones, sec_tens, sec_ones,
                  digits_entered, finished, input ready);
  modport sink   (input valid, mode, min_tens, min_ones, sec_tens, sec_ones,
                  digits_entered, finished, output ready);
endinterface

/* sv/keypad_countdown_timer.sv */
// Minutes:seconds countdown timer driven by keypad samples and one-second ticks.
// Each accepted item updates the timer state in the same cycle and yields exactly
// one output item showing mode, the four BCD digits, the entry count and a done
// flag. A new item is taken every cycle; the only limit is the single output
// register, which accepts a new item whenever it is empty or being drained in
// the same cycle. A fresh '*' restarts entry from any mode, four fresh digit
// keys arm the timer (tens clamped to 5), '#' starts the count and ticks then
// count down to 00:00 and done.
// depends on kct_pkg and the kct_in_if / kct_out_if interfaces
module keypad_countdown_timer
  import kct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  kct_in_if.sink    in_ch,
  kct_out_if.source out_ch
);

  // timer state
  mode_t            mode_reg;
  mode_t            mode_next;
  logic [IDX_W-1:0] entry_index;
  logic [IDX_W-1:0] entry_index_next;
  logic [3:0]       time_digits      [NUM_DIGITS];
  logic [3:0]       time_digits_next [NUM_DIGITS];
  logic [7:0]       previous_key;
  logic [7:0]       previous_key_next;

  // output register
  logic out_valid;
  logic accept;

  // decoded item
  logic is_key;
  logic is_tick;
  logic fresh;
  logic fresh_star;
  logic is_digit;
  logic take_digit;
  logic all_zero;
  logic [IDX_W-1:0] idx_inc;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // item decode
  assign is_key     = (in_ch.kind == KIND_KEY);
  assign is_tick    = (in_ch.kind == KIND_TICK);
  assign fresh      = (in_ch.key_code != previous_key);
  assign fresh_star = fresh && (in_ch.key_code == KEY_STAR);
  assign is_digit   = (in_ch.key_code >= KEY_ZERO) && (in_ch.key_code <= KEY_NINE);
  assign take_digit = fresh && is_digit && !entry_index[IDX_W-1];
  assign idx_inc    = take_digit ? entry_index + IDX_W'(1) : entry_index;
  assign all_zero   = (time_digits[0] == 4'd0) && (time_digits[1] == 4'd0) &&
                      (time_digits[2] == 4'd0) && (time_digits[3] == 4'd0);

  // next mode
  always_comb begin
    mode_next = mode_reg;
    if (is_key) begin
      if (fresh_star) begin
        mode_next = MODE_ENTER;
      end else begin
        unique case (mode_reg)
          MODE_ENTER: if (idx_inc[IDX_W-1]) mode_next = MODE_ARMED;
          MODE_ARMED: if (in_ch.key_code == KEY_HASH) mode_next = MODE_COUNT;
          default:    mode_next = mode_reg;
        endcase
      end
    end else if (mode_reg == MODE_COUNT && all_zero) begin
      mode_next = MODE_DONE;
    end
  end

  // next digits, entry count and last key
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) time_digits_next[i] = time_digits[i];
    entry_index_next  = entry_index;
    previous_key_next = previous_key;
    if (is_key) begin
      previous_key_next = in_ch.key_code;
      if (fresh_star || mode_reg == MODE_IDLE) begin
        for (int i = 0; i < NUM_DIGITS; i++) time_digits_next[i] = 4'd0;
        entry_index_next = '0;
      end else if (mode_reg == MODE_ENTER) begin
        if (take_digit) time_digits_next[entry_index[1:0]] = in_ch.key_code[3:0];
        entry_index_next = idx_inc;
        // clamp tens digits once all four are in
        if (idx_inc[IDX_W-1]) begin
          if (time_digits_next[0] > TENS_LIMIT) time_digits_next[0] = TENS_LIMIT;
          if (time_digits_next[2] > TENS_LIMIT) time_digits_next[2] = TENS_LIMIT;
        end
      end
    end else if (mode_reg == MODE_COUNT && !all_zero) begin
      // bcd decrement with seconds borrow to 59
      if (time_digits[3] != 4'd0) begin
        time_digits_next[3] = time_digits[3] - 4'd1;
      end else if (time_digits[2] != 4'd0) begin
        time_digits_next[2] = time_digits[2] - 4'd1;
        time_digits_next[3] = DIGIT_MAX;
      end else begin
        time_digits_next[2] = TENS_LIMIT;
        time_digits_next[3] = DIGIT_MAX;
        if (time_digits[1] != 4'd0) begin
          time_digits_next[1] = time_digits[1] - 4'd1;
        end else begin
          time_digits_next[0] = time_digits[0] - 4'd1;
          time_digits_next[1] = DIGIT_MAX;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_IDLE;
      entry_index  <= '0;
      previous_key <= KEY_NONE;
      for (int i = 0; i < NUM_DIGITS; i++) time_digits[i] <= 4'd0;
    end else if (accept) begin
      mode_reg     <= mode_next;
      entry_index  <= entry_index_next;
      previous_key <= previous_key_next;
      for (int i = 0; i < NUM_DIGITS; i++) time_digits[i] <= time_digits_next[i];
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.mode           <= mode_next;
      out_ch.min_tens       <= time_digits_next[0];
      out_ch.min_ones       <= time_digits_next[1];
      out_ch.sec_tens       <= time_digits_next[2];
      out_ch.sec_ones       <= time_digits_next[3];
      out_ch.digits_entered <= entry_index_next;
      out_ch.finished       <= (mode_next == MODE_DONE);
    end
  end

  assign out_ch.valid = out_valid;

  // entry never holds a full digit count
  a_enter_idx: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_ENTER |-> !entry_index[IDX_W-1])
    else $error("entry mode with full digit count");

  // tens digits stay clamped while counting
  a_count_tens: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_COUNT |-> (time_digits[0] <= TENS_LIMIT) &&
                                (time_digits[2] <= TENS_LIMIT))
    else $error("tens digit above limit while counting");

  // a tick at zero ends the count
  a_zero_done: assert property (@(posedge clk) disable iff (rst)
    accept && is_tick && mode_reg == MODE_COUNT && all_zero |=> mode_reg == MODE_DONE)
    else $error("count at zero did not reach done");

  // shown flag agrees with shown mode
  a_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ch.finished == (out_ch.mode == MODE_DONE)))
    else $error("finished flag disagrees with mode");

endmodule
